@@ sv/crt_pkg.sv @@
// Shared types and constants for the CSV row tokenizer.
package crt_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_CELL = 2'd1;
    localparam logic [1:0] KIND_ROW  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic take;
        logic flush_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic flush_req;
        logic flush_last;
    } t_dp_status;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ sv/csv_row_tokenizer.sv @@
// Top level: CSV row tokenizer, stream in and out.
// Output is registered; held whitespace is emitted ahead of the content byte releasing it.
// Throughput: one byte per cycle while no trailing whitespace is held and output is
// not stalled; held whitespace bytes released by a content byte are read out through
// the single read port of the pending whitespace store, and input stalls meanwhile.
// Reset: synchronous active-low; clears quote, cell and store-count state, no clearing pass.
module csv_row_tokenizer #(
    parameter int SPACE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // row_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] cell_overflow
    output logic       m_axis_tlast    // last
);

    crt_pkg::t_dp_cmd    cmd;
    crt_pkg::t_dp_status status;
    logic [1:0]          kind;
    logic                cell_ovf;

    crt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    crt_dp #(
        .SPACE_DEPTH (SPACE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (s_axis_tdata),
        .i_row_end       (s_axis_tlast),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_byte      (m_axis_tdata),
        .o_kind          (kind),
        .o_cell_overflow (cell_ovf),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tuser = {cell_ovf, kind};

endmodule

@@ sv/crt_ctrl.sv @@
// Controller: input handshake and whitespace flush sequencing.
module crt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crt_pkg::t_dp_status i_status,
    output crt_pkg::t_dp_cmd    o_cmd
);

    crt_pkg::t_state r_state;
    crt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.take       = 1'b0;
        o_cmd.flush_emit = 1'b0;
        unique case (r_state)
            crt_pkg::ST_IDLE: begin
                o_in_ready = i_status.slot_free;
                o_cmd.take = i_in_valid && i_status.slot_free;
                if (o_cmd.take && i_status.flush_req) begin
                    n_state = crt_pkg::ST_FLUSH;
                end
            end
            crt_pkg::ST_FLUSH: begin
                o_cmd.flush_emit = i_status.slot_free;
                if (i_status.slot_free && i_status.flush_last) begin
                    n_state = crt_pkg::ST_IDLE;
                end
            end
            default: n_state = crt_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ sv/crt_dp.sv @@
// Datapath: quote/cell state, pending whitespace store and output register.
module crt_dp #(
    parameter int SPACE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_in_byte,
    input  logic                i_row_end,
    input  crt_pkg::t_dp_cmd    i_cmd,
    output crt_pkg::t_dp_status o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic [1:0]          o_kind,
    output logic                o_cell_overflow,
    output logic                o_last
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);
    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);

    logic [7:0]    r_mem [SPACE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_in_quotes, n_in_quotes;
    logic          r_quote_pend, n_quote_pend;
    logic          r_content_seen, n_content_seen;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_held;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [1:0]    r_out_kind;
    logic          r_out_ovf;
    logic          r_out_last;

    logic          slot_free;
    logic          in_q_eff;
    logic          c_quote;
    logic          c_comma;
    logic          c_cr;
    logic          c_space;
    logic          is_content;
    logic          cell_end;
    logic          wr_en;
    logic          load;
    logic [7:0]    ld_byte;
    logic [1:0]    ld_kind;
    logic          ld_ovf;
    logic          ld_last;
    logic          flush_req;
    logic          flush_last;
    logic [CW-1:0] rd_sel;
    logic [AW-1:0] rd_addr;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign c_quote    = (i_in_byte == crt_pkg::CH_QUOTE);
    assign c_comma    = (i_in_byte == crt_pkg::CH_COMMA);
    assign c_cr       = (i_in_byte == crt_pkg::CH_CR);
    assign c_space    = crt_pkg::is_space(i_in_byte);
    assign in_q_eff   = r_in_quotes && !r_quote_pend;
    assign is_content = (r_quote_pend && c_quote) ||
                        (!c_quote && !(c_comma && !in_q_eff) && !c_cr);
    assign cell_end   = !i_row_end && !(r_quote_pend && c_quote) && !c_quote &&
                        c_comma && !in_q_eff;
    assign flush_req  = !i_row_end && is_content && !c_space && (r_count != '0);
    assign flush_last = (r_idx == r_count);
    assign wr_en      = i_cmd.take && !i_row_end && is_content && c_space &&
                        r_content_seen && (r_count < DEPTH_C);

    assign o_status.slot_free  = slot_free;
    assign o_status.flush_req  = flush_req;
    assign o_status.flush_last = flush_last;

    always_comb begin
        n_in_quotes    = r_in_quotes;
        n_quote_pend   = r_quote_pend;
        n_content_seen = r_content_seen;
        n_count        = r_count;
        n_ovf          = r_ovf;
        n_idx          = r_idx;
        load           = 1'b0;
        ld_byte        = 8'h00;
        ld_kind        = crt_pkg::KIND_DATA;
        ld_ovf         = 1'b0;
        ld_last        = 1'b1;
        if (i_cmd.take) begin
            n_idx = '0;
            if (i_row_end) begin
                n_in_quotes    = 1'b0;
                n_quote_pend   = 1'b0;
                n_content_seen = 1'b0;
                n_count        = '0;
                n_ovf          = 1'b0;
                load           = 1'b1;
                ld_kind        = crt_pkg::KIND_ROW;
                ld_ovf         = r_ovf;
            end else begin
                n_quote_pend = 1'b0;
                if (!(r_quote_pend && c_quote)) begin
                    n_in_quotes = c_quote ? 1'b1 : in_q_eff;
                    if (c_quote) begin
                        n_quote_pend = in_q_eff;
                    end
                end
                if (cell_end) begin
                    n_content_seen = 1'b0;
                    n_count        = '0;
                    n_ovf          = 1'b0;
                    load           = 1'b1;
                    ld_kind        = crt_pkg::KIND_CELL;
                    ld_ovf         = r_ovf;
                end else if (is_content) begin
                    if (c_space) begin
                        if (r_content_seen) begin
                            if (r_count < DEPTH_C) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else begin
                        n_content_seen = 1'b1;
                        if (r_count == '0) begin
                            load    = 1'b1;
                            ld_byte = i_in_byte;
                        end
                    end
                end
            end
        end else if (i_cmd.flush_emit) begin
            load = 1'b1;
            if (flush_last) begin
                ld_byte = r_held;
                n_count = '0;
            end else begin
                ld_byte = r_rd_data;
                ld_last = 1'b0;
                n_idx   = r_idx + 1'b1;
            end
        end
    end

    // read address tracks the next index so r_rd_data holds entry r_idx whenever a flush reads it
    assign rd_sel  = (i_cmd.flush_emit && !flush_last) ? (r_idx + 1'b1) :
                     (i_cmd.take ? '0 : r_idx);
    assign rd_addr = (rd_sel < DEPTH_C) ? rd_sel[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_in_byte;
        end
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.take) begin
            r_held <= i_in_byte;
        end
        if (load) begin
            r_out_byte <= ld_byte;
            r_out_kind <= ld_kind;
            r_out_ovf  <= ld_ovf;
            r_out_last <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes    <= 1'b0;
            r_quote_pend   <= 1'b0;
            r_content_seen <= 1'b0;
            r_count        <= '0;
            r_ovf          <= 1'b0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_in_quotes    <= n_in_quotes;
            r_quote_pend   <= n_quote_pend;
            r_content_seen <= n_content_seen;
            r_count        <= n_count;
            r_ovf          <= n_ovf;
            r_idx          <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_kind          = r_out_kind;
    assign o_cell_overflow = r_out_ovf;
    assign o_last          = r_out_last;

endmodule

@@ sv/crt_checker.sv @@
// Port-level checker for the CSV row tokenizer, bound to the top level.
module crt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_burst_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted during whitespace flush");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != crt_pkg::KIND_DATA) |-> m_axis_tlast)
        else $error("cell end not marked last");

    a_data_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == crt_pkg::KIND_DATA) |-> !m_axis_tuser[2])
        else $error("overflow flag on content byte");

endmodule

bind csv_row_tokenizer crt_checker u_crt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
